[rtl/mkscan_pkg.sv]
// Shared types, constants and keymap ROM for the keyboard matrix scanner.
package mkscan_pkg;

	localparam int ROWS_DEF          = 5;
	localparam int FN_ROW_OFFSET_DEF = 5;
	localparam int COLS              = 14;
	localparam int COL_W             = $clog2(COLS);
	localparam int ROW_W             = 3;
	localparam int CODE_W            = 9;
	localparam int ROM_IDX_W         = 10;

	localparam logic [CODE_W-1:0] CODE_EMPTY = 9'd0;
	localparam logic [CODE_W-1:0] KEY_FN     = 9'd464;

	localparam logic EV_KEY  = 1'b0;
	localparam logic EV_SYNC = 1'b1;

	typedef struct packed {
		logic [ROW_W-1:0] row_index;
		logic [COLS-1:0]  column_levels;
	} item_t;

	typedef struct packed {
		logic              event_kind;
		logic [CODE_W-1:0] key_code;
		logic              key_value;
		logic              last;
	} result_t;

	typedef struct packed {
		logic              val;
		logic              chg_b;
		logic              chg_f;
		logic [CODE_W-1:0] code_b;
		logic [CODE_W-1:0] code_f;
	} lane_t;

	typedef struct packed {
		logic start;
		logic last_row;
	} mg_cmd_t;

	typedef struct packed {
		logic            done;
		logic [COLS-1:0] flip_b;
		logic [COLS-1:0] flip_f;
	} mg_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD_B,
		ST_LOAD_F,
		ST_LANE,
		ST_WALK,
		ST_STORE_B,
		ST_STORE_F
	} top_st_t;

	typedef enum logic [1:0] {
		MG_IDLE,
		MG_COL,
		MG_SYNC,
		MG_FLUSH
	} mg_st_t;

	function automatic logic [CODE_W-1:0] keymap_code(input logic [ROM_IDX_W-1:0] idx);
		logic [CODE_W-1:0] code;
		code = CODE_EMPTY;
		case (idx) inside
			[10'd0:10'd26]:  code = CODE_W'(idx + 10'd1);
			10'd27:          code = 9'd43;
			10'd28:          code = 9'd58;
			[10'd29:10'd39]: code = CODE_W'(idx + 10'd1);
			10'd41:          code = 9'd28;
			10'd42:          code = 9'd42;
			[10'd43:10'd52]: code = CODE_W'(idx + 10'd1);
			10'd53:          code = 9'd41;
			10'd54:          code = 9'd103;
			10'd55:          code = 9'd111;
			10'd56:          code = 9'd29;
			10'd57:          code = 9'd125;
			10'd58:          code = 9'd56;
			10'd61:          code = 9'd57;
			10'd65:          code = KEY_FN;
			10'd66:          code = 9'd110;
			10'd67:          code = 9'd105;
			10'd68:          code = 9'd108;
			10'd69:          code = 9'd106;
			[10'd71:10'd80]: code = CODE_W'(idx - 10'd12);
			10'd81:          code = 9'd87;
			10'd82:          code = 9'd88;
			10'd124:         code = 9'd104;
			10'd135:         code = KEY_FN;
			10'd137:         code = 9'd102;
			10'd138:         code = 9'd109;
			10'd139:         code = 9'd107;
			default:         code = CODE_EMPTY;
		endcase
		return code;
	endfunction

endpackage

[rtl/mkscan_lane.sv]
// One column lane: change detection and keymap lookup for both layers.
module mkscan_lane import mkscan_pkg::*; #(
	parameter int COL    = 0,
	parameter int LROW_W = 4
) (
	input  logic              clk,
	input  logic              en,
	input  logic              level,
	input  logic              old_b,
	input  logic              old_f,
	input  logic [LROW_W-1:0] lrow_b,
	input  logic [LROW_W-1:0] lrow_f,
	output lane_t             info
);

	lane_t                 lane_q;
	logic                  val;
	logic [ROM_IDX_W-1:0]  idx_b;
	logic [ROM_IDX_W-1:0]  idx_f;

	assign val   = ~level;
	assign idx_b = ROM_IDX_W'(lrow_b) * ROM_IDX_W'(COLS) + ROM_IDX_W'(COL);
	assign idx_f = ROM_IDX_W'(lrow_f) * ROM_IDX_W'(COLS) + ROM_IDX_W'(COL);

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q.val    <= val;
			lane_q.chg_b  <= val ^ old_b;
			lane_q.chg_f  <= val ^ old_f;
			lane_q.code_b <= keymap_code(idx_b);
			lane_q.code_f <= keymap_code(idx_f);
		end
	end

	assign info = lane_q;

endmodule

[rtl/mkscan_merge.sv]
// Column walk over the lane results: Fn tracking, event ordering and result register.
module mkscan_merge import mkscan_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  mg_cmd_t    cmd,
	input  lane_t      lanes [COLS],
	output mg_status_t status,
	output logic       result_valid,
	input  logic       result_stall,
	output result_t    result
);

	mg_st_t            state_q, state_d;
	logic [COL_W-1:0]  col_q;
	logic              fn_q;
	logic              frame_q;
	logic              last_row_q;
	logic              pend_v_q;
	result_t           pend_q;
	logic              res_valid_q;
	result_t           res_q;
	logic [COLS-1:0]   flip_b_q;
	logic [COLS-1:0]   flip_f_q;

	lane_t             info;
	logic              chg;
	logic [CODE_W-1:0] code;
	logic              is_fn;
	logic              ev_hit;
	result_t           ev_data;
	logic              out_free;
	logic              place_ok;
	logic              push;
	result_t           push_data;
	logic              step;
	logic              done;

	assign info     = lanes[col_q];
	assign chg      = fn_q ? info.chg_f : info.chg_b;
	assign code     = fn_q ? info.code_f : info.code_b;
	assign is_fn    = (code == KEY_FN);
	assign out_free = !res_valid_q || !result_stall;
	assign place_ok = !pend_v_q || out_free;

	always_comb begin
		state_d   = state_q;
		ev_hit    = 1'b0;
		ev_data   = '0;
		push      = 1'b0;
		push_data = pend_q;
		step      = 1'b0;
		done      = 1'b0;
		case (state_q)
			MG_IDLE: begin
				if (cmd.start) begin
					state_d = MG_COL;
				end
			end
			MG_COL: begin
				ev_hit             = chg && !is_fn;
				ev_data.event_kind = EV_KEY;
				ev_data.key_code   = code;
				ev_data.key_value  = info.val;
				step               = !ev_hit || place_ok;
				push               = ev_hit && pend_v_q && out_free;
				if (step && col_q == COL_W'(COLS - 1)) begin
					state_d = MG_SYNC;
				end
			end
			MG_SYNC: begin
				ev_hit             = last_row_q && frame_q;
				ev_data.event_kind = EV_SYNC;
				push               = ev_hit && pend_v_q && out_free;
				if (!ev_hit || place_ok) begin
					state_d = MG_FLUSH;
				end
			end
			MG_FLUSH: begin
				push           = pend_v_q && out_free;
				push_data.last = 1'b1;
				done           = !pend_v_q || out_free;
				if (done) begin
					state_d = MG_IDLE;
				end
			end
			default: begin
				state_d = MG_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= MG_IDLE;
			col_q       <= '0;
			fn_q        <= 1'b0;
			frame_q     <= 1'b0;
			last_row_q  <= 1'b0;
			pend_v_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == MG_IDLE && cmd.start) begin
				col_q      <= '0;
				last_row_q <= cmd.last_row;
			end
			if (step) begin
				col_q <= col_q + 1'b1;
				if (chg && is_fn) begin
					fn_q <= info.val;
				end
			end
			if (ev_hit && place_ok) begin
				pend_v_q <= 1'b1;
				if (state_q == MG_COL) begin
					frame_q <= 1'b1;
				end
			end else if (state_q == MG_FLUSH && push) begin
				pend_v_q <= 1'b0;
			end
			if (state_q == MG_SYNC && (!ev_hit || place_ok) && last_row_q) begin
				frame_q <= 1'b0;
			end
			if (push) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == MG_IDLE && cmd.start) begin
			flip_b_q <= '0;
			flip_f_q <= '0;
		end
		if (step && chg) begin
			if (fn_q) begin
				flip_f_q[col_q] <= 1'b1;
			end else begin
				flip_b_q[col_q] <= 1'b1;
			end
		end
		if (ev_hit && place_ok) begin
			pend_q <= ev_data;
		end
		if (push) begin
			res_q <= push_data;
		end
	end

	assign status.done   = done;
	assign status.flip_b = flip_b_q;
	assign status.flip_f = flip_f_q;
	assign result_valid  = res_valid_q;
	assign result        = res_q;

endmodule

[rtl/matrix_keyboard_scan_fn_layer_core.sv]
// Keyboard matrix scanner with Fn layer: top level, row store and control.
//
// Input channel (item_valid / item_stall / item): one beat per scanned row,
// carrying the row number and the active-low column levels.
// Output channel (result_valid / result_stall / result): key events in column
// order, then a sync beat after the last row of a frame that saw any event.
// The last beat caused by a row carries last = 1; a row with no key event gives
// no beats unless it ends a frame that saw one, and an out-of-range row is
// taken and dropped while the scanner stays idle. From acceptance to the next
// acceptance a row goes through two row-store reads, the lane register, the
// merge walk at one column per cycle unless a stall holds it, sync and flush,
// then two write-backs. Each key event waits in a one-beat hold until the next
// event or the row end, since its last flag depends on what follows.
// When the receiver stalls, the walk holds on the column that has an event to
// place, and the input channel stays stalled until the row is written back.
// Reset clears all pressed bits, the Fn flag and the frame event flag, and
// empties the output register.
module matrix_keyboard_scan_fn_layer_core import mkscan_pkg::*; #(
	parameter int ROWS          = ROWS_DEF,
	parameter int FN_ROW_OFFSET = FN_ROW_OFFSET_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int LROWS  = ROWS + FN_ROW_OFFSET;
	localparam int LROW_W = $clog2(LROWS);

	top_st_t           state_q, state_d;
	item_t             item_q;
	logic [COLS-1:0]   pressed_q [LROWS];
	logic [COLS-1:0]   old_b_q;
	logic [COLS-1:0]   old_f_q;
	logic [5:0]        sum_b;
	logic [5:0]        sum_f;
	logic [LROW_W-1:0] lrow_b;
	logic [LROW_W-1:0] lrow_f;
	logic [LROW_W-1:0] rd_addr;
	logic              in_range;
	logic              accept;
	logic              lane_en;
	mg_cmd_t           cmd;
	mg_status_t        status;
	lane_t             lanes [COLS];

	assign sum_b    = 6'(item_q.row_index);
	assign sum_f    = sum_b + 6'(FN_ROW_OFFSET);
	assign lrow_b   = sum_b[LROW_W-1:0];
	assign lrow_f   = sum_f[LROW_W-1:0];
	assign rd_addr  = (state_q == ST_LOAD_B) ? lrow_b : lrow_f;
	assign in_range = 5'(item.row_index) < 5'(ROWS);
	assign accept   = item_valid && !item_stall;
	assign lane_en  = (state_q == ST_LANE);

	always_comb begin
		state_d      = state_q;
		item_stall   = 1'b1;
		cmd.start    = 1'b0;
		cmd.last_row = 5'(item_q.row_index) == 5'(ROWS - 1);
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid && in_range) begin
					state_d = ST_LOAD_B;
				end
			end
			ST_LOAD_B: state_d = ST_LOAD_F;
			ST_LOAD_F: state_d = ST_LANE;
			ST_LANE: begin
				cmd.start = 1'b1;
				state_d   = ST_WALK;
			end
			ST_WALK: begin
				if (status.done) begin
					state_d = ST_STORE_B;
				end
			end
			ST_STORE_B: state_d = ST_STORE_F;
			ST_STORE_F: state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int r = 0; r < LROWS; r++) begin
				pressed_q[r] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == ST_STORE_B) begin
				pressed_q[lrow_b] <= old_b_q ^ status.flip_b;
			end
			if (state_q == ST_STORE_F) begin
				pressed_q[lrow_f] <= old_f_q ^ status.flip_f;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		if (state_q == ST_LOAD_B) begin
			old_b_q <= pressed_q[rd_addr];
		end
		if (state_q == ST_LOAD_F) begin
			old_f_q <= pressed_q[rd_addr];
		end
	end

	for (genvar j = 0; j < COLS; j++) begin : g_lane
		mkscan_lane #(
			.COL    (j),
			.LROW_W (LROW_W)
		) u_lane (
			.clk    (clk),
			.en     (lane_en),
			.level  (item_q.column_levels[j]),
			.old_b  (old_b_q[j]),
			.old_f  (old_f_q[j]),
			.lrow_b (lrow_b),
			.lrow_f (lrow_f),
			.info   (lanes[j])
		);
	end

	mkscan_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.lanes        (lanes),
		.status       (status),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

[test/tb.sv]
// Testbench for the keyboard matrix scanner with Fn layer: directed and random row beats.
`timescale 1ns / 100ps

module tb import mkscan_pkg::*;;

	localparam int ROWS       = ROWS_DEF;
	localparam int FN_OFFSET  = FN_ROW_OFFSET_DEF;
	localparam int LAYER_ROWS = ROWS + FN_OFFSET;
	localparam int MAP_SIZE   = 140;
	localparam int LIMIT      = 1000000;

	localparam logic [CODE_W-1:0] KEYMAP [0:MAP_SIZE-1] = '{
		1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14,
		15, 16, 17, 18, 19, 20, 21, 22, 23, 24, 25, 26, 27, 43,
		58, 30, 31, 32, 33, 34, 35, 36, 37, 38, 39, 40, CODE_EMPTY, 28,
		42, 44, 45, 46, 47, 48, 49, 50, 51, 52, 53, 41, 103, 111,
		29, 125, 56, CODE_EMPTY, CODE_EMPTY, 57, CODE_EMPTY, CODE_EMPTY, CODE_EMPTY, KEY_FN,
		110, 105, 108, 106,
		CODE_EMPTY, 59, 60, 61, 62, 63, 64, 65, 66, 67, 68, 87, 88, CODE_EMPTY,
		0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
		0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
		0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 104, 0,
		0, 0, 0, 0, 0, 0, 0, 0, 0, KEY_FN, 0, 102, 109, 107
	};

	typedef struct {
		item_t beat;
		bit    drain;
	} row_job_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	row_job_t        row_jobs [$];
	result_t         key_events_due [$];
	logic [COLS-1:0] held_keys [LAYER_ROWS];
	logic            fn_on;
	logic            frame_event;

	int sent_count  = 0;
	int total_items = 0;
	int errors      = 0;
	int cycle_count = 0;
	int send_gap    = 0;
	int drain_quiet = 0;
	int stall_left  = 0;
	int beat_no     = 0;

	matrix_keyboard_scan_fn_layer_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #10 clk = ~clk;

	function automatic logic [CODE_W-1:0] keymap_lookup(input int idx);
		if (idx >= MAP_SIZE)
			return CODE_EMPTY;
		return KEYMAP[idx];
	endfunction

	function automatic int pick_pause(input bit calm, input int idle_pct);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < idle_pct)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic scan_row(input item_t it);
		result_t batch [$];
		result_t r;
		int      lrow;
		logic    val;
		logic    old;
		logic [CODE_W-1:0] code;
		if (it.row_index >= ROWS)
			return;
		for (int j = 0; j < COLS; j++) begin
			lrow = int'(it.row_index) + (fn_on ? FN_OFFSET : 0);
			val  = ~it.column_levels[j];
			old  = held_keys[lrow][j];
			if (val != old) begin
				held_keys[lrow][j] = val;
				code = keymap_lookup(lrow * COLS + j);
				if (code == KEY_FN) begin
					fn_on = val;
				end else begin
					r.event_kind = EV_KEY;
					r.key_code   = code;
					r.key_value  = val;
					r.last       = 1'b0;
					batch.push_back(r);
					frame_event = 1'b1;
				end
			end
		end
		if (it.row_index == ROWS - 1) begin
			if (frame_event) begin
				r.event_kind = EV_SYNC;
				r.key_code   = CODE_EMPTY;
				r.key_value  = 1'b0;
				r.last       = 1'b0;
				batch.push_back(r);
			end
			frame_event = 1'b0;
		end
		if (batch.size() != 0)
			batch[$].last = 1'b1;
		foreach (batch[k])
			key_events_due.push_back(batch[k]);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at beat %0d, %s: got %0d want %0d", beat_no, what, got, want);
		errors++;
	endtask

	task automatic check_beat(input result_t got);
		result_t want;
		if (key_events_due.size() == 0) begin
			report_mismatch("unexpected beat, key_code", got.key_code, 0);
		end else begin
			want = key_events_due.pop_front();
			if (got.event_kind !== want.event_kind)
				report_mismatch("event_kind", got.event_kind, want.event_kind);
			if (got.key_code !== want.key_code)
				report_mismatch("key_code", got.key_code, want.key_code);
			if (got.key_value !== want.key_value)
				report_mismatch("key_value", got.key_value, want.key_value);
			if (got.last !== want.last)
				report_mismatch("last", got.last, want.last);
		end
		beat_no++;
	endtask

	task automatic queue_row(input int row, input logic [COLS-1:0] levels, input bit drain);
		row_job_t job;
		job.beat.row_index     = ROW_W'(row);
		job.beat.column_levels = levels;
		job.drain              = drain;
		row_jobs.push_back(job);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item       <= '0;
			send_gap   <= 0;
		end else begin
			if (item_valid && !item_stall) begin
				scan_row(item);
				sent_count++;
			end
			if (key_events_due.size() == 0) begin
				if (drain_quiet < 1000)
					drain_quiet++;
			end else begin
				drain_quiet = 0;
			end
			if (!item_valid || !item_stall) begin
				if (send_gap > 0) begin
					send_gap   <= send_gap - 1;
					item_valid <= 1'b0;
				end else if (row_jobs.size() == 0 || (row_jobs[0].drain && drain_quiet < 40)) begin
					item_valid <= 1'b0;
				end else begin
					item       <= row_jobs[0].beat;
					item_valid <= 1'b1;
					send_gap   <= pick_pause(((sent_count / 40) % 4) == 3, 50);
					void'(row_jobs.pop_front());
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin : monitor
		int pause;
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left   <= 0;
		end else begin
			if (result_valid && !result_stall)
				check_beat(result);
			if (stall_left > 0) begin
				result_stall <= 1'b1;
				stall_left   <= stall_left - 1;
			end else begin
				pause = pick_pause(((cycle_count / 500) % 5) == 4, 60);
				result_stall <= (pause > 0);
				stall_left   <= (pause > 0) ? pause - 1 : 0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		logic [COLS-1:0] down [ROWS];
		logic [COLS-1:0] levels;
		int  live;
		int  pick;
		int  row;
		bit  drained;

		foreach (held_keys[i])
			held_keys[i] = '0;
		fn_on       = 1'b0;
		frame_event = 1'b0;

		// directed: extremes, empty slot, ignored rows, Fn in both layers, Fn mid-row
		queue_row(0, 14'h3FFF, 0);
		queue_row(0, 14'h0000, 0);
		queue_row(1, 14'h0000, 0);
		queue_row(2, ~(14'h1 << 12), 0);
		queue_row(4, 14'h3FFF, 0);
		queue_row(4, 14'h3FFF, 0);
		queue_row(7, 14'h0000, 0);
		queue_row(5, 14'h0000, 0);
		queue_row(4, ~(14'h1 << 9), 0);
		queue_row(0, 14'h0000, 0);
		queue_row(4, ~(14'h1 << 9), 0);
		queue_row(4, 14'h3FFF, 0);
		queue_row(3, 14'h0000, 1);
		queue_row(4, 14'h0000, 0);
		queue_row(4, 14'h3FFF, 0);
		queue_row(4, ~((14'h1 << 2) | (14'h1 << 9) | (14'h1 << 12)), 0);
		queue_row(4, 14'h3FFF, 0);
		queue_row(4, ~(14'h1 << 9), 0);
		queue_row(4, 14'h3FFF, 0);
		queue_row(4, 14'h3FFF, 0);
		for (int r = 0; r < ROWS; r++)
			queue_row(r, 14'h3FFF, 0);

		// random frames, mostly in order, with noise rows and out-of-order rows
		foreach (down[i])
			down[i] = '0;
		live    = 0;
		drained = 0;
		while (live < 300) begin
			for (int r = 0; r < ROWS; r++) begin
				if ($urandom_range(0, 19) == 0)
					queue_row($urandom_range(ROWS, 7), COLS'($urandom_range(0, 16383)), 0);
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					levels  = COLS'($urandom_range(0, 16383));
					down[r] = ~levels;
				end else begin
					repeat ($urandom_range(0, 3))
						down[r][$urandom_range(0, COLS - 1)] ^= 1'b1;
					if (r == ROWS - 1 && $urandom_range(0, 6) == 0)
						down[r][9] ^= 1'b1;
					levels = ~down[r];
				end
				row = (pick >= 96) ? $urandom_range(0, ROWS - 1) : r;
				queue_row(row, levels, !drained && live >= 150);
				if (live >= 150)
					drained = 1;
				live++;
			end
		end
		total_items = row_jobs.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (sent_count < total_items)
			@(posedge clk);
		while (key_events_due.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[files.f]
rtl/mkscan_pkg.sv
rtl/mkscan_lane.sv
rtl/mkscan_merge.sv
rtl/matrix_keyboard_scan_fn_layer_core.sv
test/tb.sv
